### hw/rtl/particle_update_step_top_macros.svh
// Assertion macros for the particle update pipeline.
// Included by the modules that assert; depends on nothing else.
`ifndef PARTICLE_UPDATE_STEP_TOP_MACROS_SVH
`define PARTICLE_UPDATE_STEP_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PUS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PUS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/pus_pkg.sv
// Shared types, constants and helper functions of the particle update pipeline.
// No dependencies; imported by every pipeline stage and the top level.
`timescale 1ns / 1ps

package pus_pkg;

    typedef enum logic [2:0] {
        KIND_STATIC   = 3'd0,
        KIND_GRAV     = 3'd1,
        KIND_SLOWGRAV = 3'd2,
        KIND_FIRE     = 3'd3,
        KIND_EXPLODE  = 3'd4,
        KIND_EXPLODE2 = 3'd5,
        KIND_BLOB     = 3'd6,
        KIND_BLOB2    = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        GRAV_NONE = 2'd0,
        GRAV_ADD  = 2'd1,
        GRAV_SUB  = 2'd2
    } gmode_t;

    localparam logic [1:0] CFG_CURRENT_TIME = 2'd0;
    localparam logic [1:0] CFG_FRAME_TIME   = 2'd1;
    localparam logic [1:0] CFG_GRAVITY      = 2'd2;

    localparam logic [11:0] GRAVITY_RESET = 12'd800;

    localparam logic [16:0] RAMP_FIRE_END = 17'd24576;
    localparam logic [16:0] RAMP_EXPL_END = 17'd32768;
    localparam logic [31:0] DEATH_KILLED  = 32'hFFFF_0000;

    // ceil(2^25 / 5): exact floor division by 5 for operands below 2^23
    localparam logic [22:0] RECIP_FIVE  = 23'd6710887;
    localparam int          RECIP_SHIFT = 25;
    localparam int          G_W         = 20;

    localparam logic [7:0] TAB_EXPLODE  [8] = '{8'h6f, 8'h6d, 8'h6b, 8'h69,
                                                8'h67, 8'h65, 8'h63, 8'h61};
    localparam logic [7:0] TAB_EXPLODE2 [8] = '{8'h6f, 8'h6e, 8'h6d, 8'h6c,
                                                8'h6b, 8'h6a, 8'h68, 8'h66};
    localparam logic [7:0] TAB_FIRE     [8] = '{8'h6d, 8'h6b, 8'h06, 8'h05,
                                                8'h04, 8'h03, 8'h00, 8'h00};

    typedef struct packed {
        logic [30:0] current_time;
        logic [15:0] frame_time;
        logic [11:0] gravity;
    } cfg_t;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [15:0]      ramp;
        logic [7:0]       color;
        kind_t            kind;
        logic [31:0]      death;
    } part_rec_t;

    typedef struct packed {
        part_rec_t        part;
        logic             alive;
        logic [2:0][47:0] prod;
        logic [27:0]      gprod;
        logic [15:0]      ft;
    } s1_t;

    typedef struct packed {
        part_rec_t        part;
        logic             alive;
        gmode_t           gmode;
        logic [G_W-1:0]   g;
    } s2_t;

    typedef struct packed {
        part_rec_t part;
        logic      alive;
    } res_t;

    function automatic logic [31:0] sat32(logic signed [35:0] x);
        logic [31:0] r;
        if (x > 36'sh0_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (x < 36'shF_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic [7:0] ramp_color(kind_t kind, logic [2:0] idx);
        logic [7:0] c;
        case (kind)
            KIND_FIRE:    c = TAB_FIRE[idx];
            KIND_EXPLODE: c = TAB_EXPLODE[idx];
            default:      c = TAB_EXPLODE2[idx];
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/pus_mul_stage.sv
// First pipeline stage: death test and the velocity and gravity products.
// Depends on pus_pkg.
`timescale 1ns / 1ps

module pus_mul_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  pus_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  pus_pkg::part_rec_t in_part,
    output logic               out_valid,
    input  logic               out_ready,
    output pus_pkg::s1_t       out_data
);
    import pus_pkg::*;

    logic valid_reg;
    s1_t  data_reg;
    s1_t  data_next;
    logic stage_en;

    assign stage_en  = !valid_reg || out_ready;
    assign in_ready  = stage_en;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next.part  = in_part;
        data_next.alive = !($signed(in_part.death) < $signed({1'b0, cfg.current_time}));
        for (int i = 0; i < 3; i++) begin
            data_next.prod[i] = 48'($signed(in_part.vel[i]) * $signed({1'b0, cfg.frame_time}));
        end
        data_next.gprod = 28'(cfg.frame_time) * 28'(cfg.gravity);
        data_next.ft    = cfg.frame_time;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (stage_en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

### hw/rtl/pus_apply_stage.sv
// Second pipeline stage: position step, per-kind velocity rule, color ramp
// and the gravity step by reciprocal multiply. Depends on pus_pkg.
`timescale 1ns / 1ps

module pus_apply_stage (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  pus_pkg::s1_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output pus_pkg::s2_t out_data
);
    import pus_pkg::*;

    logic valid_reg;
    s2_t  data_reg;
    s2_t  data_next;
    logic stage_en;

    assign stage_en  = !valid_reg || out_ready;
    assign in_ready  = stage_en;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        logic signed [47:0] prod;
        logic signed [35:0] p36;
        logic signed [35:0] v36;
        logic signed [35:0] d36;
        logic signed [35:0] e36;
        logic signed [35:0] vsum;
        logic [44:0]        gmul;
        logic [3:0]         inc_k;
        logic [16:0]        ramp_end;
        logic [19:0]        ramp_inc;
        logic [16:0]        ramp_sum;

        data_next.part  = in_data.part;
        data_next.alive = in_data.alive;
        data_next.gmode = GRAV_NONE;
        prod = '0;
        p36  = '0;
        v36  = '0;
        d36  = '0;
        e36  = '0;
        vsum = '0;

        // frame_time * gravity / 320: drop six bits, then divide by five
        gmul        = 45'(in_data.gprod[27:6]) * 45'(RECIP_FIVE);
        data_next.g = gmul[RECIP_SHIFT +: G_W];

        case (in_data.part.kind)
            KIND_FIRE: begin
                inc_k    = 4'd5;
                ramp_end = RAMP_FIRE_END;
            end
            KIND_EXPLODE: begin
                inc_k    = 4'd10;
                ramp_end = RAMP_EXPL_END;
            end
            KIND_EXPLODE2: begin
                inc_k    = 4'd15;
                ramp_end = RAMP_EXPL_END;
            end
            default: begin
                inc_k    = 4'd0;
                ramp_end = RAMP_EXPL_END;
            end
        endcase
        ramp_inc = 20'(in_data.ft) * 20'(inc_k);
        ramp_sum = 17'(in_data.part.ramp) + 17'(ramp_inc[19:4]);

        if (in_data.alive) begin
            for (int i = 0; i < 3; i++) begin
                prod = $signed(in_data.prod[i]);
                p36  = 36'($signed(in_data.part.pos[i]));
                v36  = 36'($signed(in_data.part.vel[i]));
                d36  = 36'(prod >>> 14);
                e36  = 36'(prod >>> 16);
                data_next.part.pos[i] = sat32(p36 + e36);
                case (in_data.part.kind)
                    KIND_EXPLODE, KIND_BLOB: vsum = v36 + d36;
                    KIND_EXPLODE2:           vsum = v36 - e36;
                    KIND_BLOB2:              vsum = (i != 2) ? v36 - d36 : v36;
                    default:                 vsum = v36;
                endcase
                data_next.part.vel[i] = sat32(vsum);
            end

            if (in_data.part.kind inside {KIND_FIRE, KIND_EXPLODE, KIND_EXPLODE2}) begin
                // ramp end kills the particle and keeps the old color
                if (ramp_sum >= ramp_end) begin
                    data_next.part.death = DEATH_KILLED;
                end else begin
                    data_next.part.color = ramp_color(in_data.part.kind, ramp_sum[14:12]);
                end
                data_next.part.ramp = ramp_sum[16] ? 16'hFFFF : ramp_sum[15:0];
            end

            case (in_data.part.kind)
                KIND_STATIC: data_next.gmode = GRAV_NONE;
                KIND_FIRE:   data_next.gmode = GRAV_ADD;
                default:     data_next.gmode = GRAV_SUB;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (stage_en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

### hw/rtl/pus_grav_stage.sv
// Third pipeline stage and output register: applies gravity to vel_z.
// Depends on pus_pkg.
`timescale 1ns / 1ps

module pus_grav_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  pus_pkg::s2_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output pus_pkg::res_t out_data
);
    import pus_pkg::*;

    logic valid_reg;
    res_t data_reg;
    res_t data_next;
    logic stage_en;

    assign stage_en  = !valid_reg || out_ready;
    assign in_ready  = stage_en;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        logic signed [35:0] vz;
        logic signed [35:0] gz;

        data_next.part  = in_data.part;
        data_next.alive = in_data.alive;
        vz = 36'($signed(in_data.part.vel[2]));
        gz = {{(36 - G_W){1'b0}}, in_data.g};
        case (in_data.gmode)
            GRAV_ADD: data_next.part.vel[2] = sat32(vz + gz);
            GRAV_SUB: data_next.part.vel[2] = sat32(vz - gz);
            default:  data_next.part.vel[2] = in_data.part.vel[2];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (stage_en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

### hw/rtl/particle_update_step_top.sv
// Particle update step: one particle per cycle through a three-stage pipeline
// while m_tready does not hold it back; every particle accepted on the
// s_ channel comes out on the m_ channel in order. The three
// register stages are the velocity-by-frame-time multipliers, the
// shift/add/saturate stage with the gravity reciprocal multiplier, and the
// gravity add feeding the output register. Configuration writes never stall
// (cfg_ready is always high) and apply to requests accepted after
// the write; write them only while no request is in flight. Dead particles
// pass through unchanged with alive low. No clearing pass follows reset.
// Depends on pus_pkg, the pus_* stage modules and the assertion macro header.
`timescale 1ns / 1ps
`include "particle_update_step_top_macros.svh"

module particle_update_step_top (
    input  logic          aclk,
    input  logic          aresetn,
    // input particle
    input  logic          s_tvalid,
    output logic          s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, ramp_in, color_in, death_time
    input  logic [247:0]  s_tdata,
    // kind
    input  logic [2:0]    s_tuser,
    // updated particle
    output logic          m_tvalid,
    input  logic          m_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    // new_ramp, new_color, new_death_time
    output logic [247:0]  m_tdata,
    // new_kind, alive
    output logic [3:0]    m_tuser,
    // configuration write
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [30:0]   cfg_data
);
    import pus_pkg::*;

    cfg_t      cfg_reg;
    part_rec_t in_part;
    logic      s1_valid;
    logic      s1_ready;
    s1_t       s1_data;
    logic      s2_valid;
    logic      s2_ready;
    s2_t       s2_data;
    res_t      res_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.current_time <= '0;
            cfg_reg.frame_time   <= '0;
            cfg_reg.gravity      <= GRAVITY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CURRENT_TIME: cfg_reg.current_time <= cfg_data;
                CFG_FRAME_TIME:   cfg_reg.frame_time   <= cfg_data[15:0];
                CFG_GRAVITY:      cfg_reg.gravity      <= cfg_data[11:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        in_part.pos[0] = s_tdata[31:0];
        in_part.pos[1] = s_tdata[63:32];
        in_part.pos[2] = s_tdata[95:64];
        in_part.vel[0] = s_tdata[127:96];
        in_part.vel[1] = s_tdata[159:128];
        in_part.vel[2] = s_tdata[191:160];
        in_part.ramp   = s_tdata[207:192];
        in_part.color  = s_tdata[215:208];
        in_part.death  = s_tdata[247:216];
        in_part.kind   = kind_t'(s_tuser);
    end

    pus_mul_stage u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_part   (in_part),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    pus_apply_stage u_apply (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    pus_grav_stage u_grav (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_data)
    );

    assign m_tdata = {res_data.part.death, res_data.part.color, res_data.part.ramp,
                      res_data.part.vel[2], res_data.part.vel[1], res_data.part.vel[0],
                      res_data.part.pos[2], res_data.part.pos[1], res_data.part.pos[0]};
    assign m_tuser = {res_data.alive, res_data.part.kind};

    `PUS_ASSERT_NEXT(a_accept_fills_s1, aclk, aresetn,
        s_tvalid && s_tready, s1_valid,
        "accepted request missing from first stage")
    `PUS_ASSERT_NEXT(a_s1_stall_holds, aclk, aresetn,
        s1_valid && !s1_ready, s1_valid && $stable(s1_data),
        "first stage lost or changed a stalled request")
    `PUS_ASSERT_IMPL(a_dead_no_gravity, aclk, aresetn,
        s2_valid && !s2_data.alive, s2_data.gmode == GRAV_NONE,
        "gravity scheduled for a dead particle")
    `PUS_ASSERT_IMPL(a_kill_only_ramp, aclk, aresetn,
        m_tvalid && m_tuser[3] && (m_tdata[247:216] == DEATH_KILLED),
        (m_tuser[2:0] == KIND_FIRE) || (m_tuser[2:0] == KIND_EXPLODE) ||
        (m_tuser[2:0] == KIND_EXPLODE2),
        "live particle killed by a kind without a ramp")

endmodule
